// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants for the ray-sphere intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // width of the reported hit distance, unsigned fixed point
    localparam int DIST_W = 32;

endpackage

// ----- rtl/rsi_ray_if.sv -----
// ----------------------------------------------------------------------------
// rsi_ray_if / rsi_res_if
// Valid/ready channels for ray-sphere test beats and their results.
// ----------------------------------------------------------------------------
interface rsi_ray_if #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [FRAC_BITS+1:0]   dir_x;
    logic signed [FRAC_BITS+1:0]   dir_y;
    logic signed [FRAC_BITS+1:0]   dir_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] sphere_radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

interface rsi_res_if
    import rsi_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              origin_inside;
    logic [DIST_W-1:0] distance;

    modport source (output valid, hit, origin_inside, distance, input ready);
    modport sink   (input  valid, hit, origin_inside, distance, output ready);
endinterface

// ----- rtl/ray_sphere_intersection.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Pipelined fixed-point ray against sphere hit test with distance.
// ----------------------------------------------------------------------------
// Input channel ray carries one ray (origin, unit direction) and one sphere
// (centre, radius) per beat; output channel res returns one beat per input
// beat, in order: hit flag, origin-inside flag and saturated hit distance.
// A new beat is taken every cycle unless the pipe is full and res is
// stalled. The pipe holds seven arithmetic stages, one stage per root
// bit of the bit-serial square root (COORD_WIDTH + 6 stages) and the
// output register. Each stage has its own valid bit and holds only while
// the stage ahead of it is full and stalled, so a stall on res fills
// empty stages first and ray stays ready until the pipe is full.
// Reset clears all valid bits; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module ray_sphere_intersection
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rsi_ray_if.sink    ray,
    rsi_res_if.source  res
);
    localparam int LW   = COORD_WIDTH + 1;          // l components
    localparam int DW   = FRAC_BITS + 2;            // direction
    localparam int RW   = COORD_WIDTH - 1;          // radius
    localparam int PDW  = LW + DW;                  // l*d
    localparam int PLW  = 2 * LW;                   // l*l
    localparam int R2W  = 2 * RW;
    localparam int SXW  = PDW + 2;                  // exact dot product
    localparam int L2W  = PLW + 2;
    localparam int SAW  = SXW - FRAC_BITS;          // |s| after truncation
    localparam int HW   = (SAW + 1) / 2;            // low half of |s|
    localparam int AW   = SAW - HW;                 // high half of |s|
    localparam int S2W  = 2 * SAW;
    localparam int NW   = S2W + 2;                  // radicand, even
    localparam int QW   = NW / 2;                   // root bits
    localparam int RMW  = QW + 3;
    localparam int EW   = (QW + 2 > DIST_W + 2) ? QW + 2 : DIST_W + 2;
    localparam int NST  = QW + 8;
    localparam int SQ0  = 7;

    typedef struct packed {
        logic           miss;
        logic           outside;
        logic           sneg;
        logic [SAW-1:0] sabs;
    } side_t;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = ~v_reg[NST-1] | res.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign ray.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= ray.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: ray to centre vector
    logic signed [LW-1:0] l_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic        [RW-1:0] r_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            l_reg[0] <= LW'(ray.center_x) - LW'(ray.origin_x);
            l_reg[1] <= LW'(ray.center_y) - LW'(ray.origin_y);
            l_reg[2] <= LW'(ray.center_z) - LW'(ray.origin_z);
            d_reg[0] <= ray.dir_x;
            d_reg[1] <= ray.dir_y;
            d_reg[2] <= ray.dir_z;
            r_reg    <= ray.sphere_radius;
        end
    end

    // stage 1: products
    logic signed [PDW-1:0] pld_reg [3];
    logic        [PLW-1:0] pll_reg [3];
    logic        [R2W-1:0] r2_1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pld_reg[k] <= l_reg[k] * d_reg[k];
                pll_reg[k] <= PLW'(l_reg[k] * l_reg[k]);
            end
            r2_1_reg <= r_reg * r_reg;
        end
    end

    // stage 2: sums
    logic signed [SXW-1:0] sex_reg;
    logic        [L2W-1:0] l2_2_reg;
    logic        [R2W-1:0] r2_2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sex_reg  <= SXW'(pld_reg[0]) + SXW'(pld_reg[1]) + SXW'(pld_reg[2]);
            l2_2_reg <= L2W'(pll_reg[0]) + L2W'(pll_reg[1]) + L2W'(pll_reg[2]);
            r2_2_reg <= r2_1_reg;
        end
    end

    // stage 3: inside test, truncate s toward zero
    logic [SXW-1:0] smag;
    side_t          side3_next;
    side_t          side3_reg;
    logic [L2W-1:0] l2_3_reg;
    logic [R2W-1:0] r2_3_reg;

    always_comb
    begin
        side3_next.sneg    = sex_reg[SXW-1];
        smag               = side3_next.sneg ? SXW'(-sex_reg) : SXW'(sex_reg);
        side3_next.sabs    = smag[SXW-1:FRAC_BITS];
        side3_next.outside = L2W'(r2_2_reg) < l2_2_reg;
        side3_next.miss    = side3_next.sneg & side3_next.outside;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            side3_reg <= side3_next;
            l2_3_reg  <= l2_2_reg;
            r2_3_reg  <= r2_2_reg;
        end
    end

    // stage 4: s squared as partial products of its halves
    logic [2*AW-1:0]     aa_reg;
    logic [AW+HW-1:0]    ab_reg;
    logic [2*HW-1:0]     bb_reg;
    side_t               side4_reg;
    logic [L2W-1:0]      l2_4_reg;
    logic [R2W-1:0]      r2_4_reg;
    logic [AW-1:0]       s_hi;
    logic [HW-1:0]       s_lo;

    assign s_hi = side3_reg.sabs[SAW-1:HW];
    assign s_lo = side3_reg.sabs[HW-1:0];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            aa_reg    <= s_hi * s_hi;
            ab_reg    <= s_hi * s_lo;
            bb_reg    <= s_lo * s_lo;
            side4_reg <= side3_reg;
            l2_4_reg  <= l2_3_reg;
            r2_4_reg  <= r2_3_reg;
        end
    end

    // stage 5: combine partial products
    logic [S2W-1:0] s2_reg;
    side_t          side5_reg;
    logic [L2W-1:0] l2_5_reg;
    logic [R2W-1:0] r2_5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s2_reg    <= (S2W'(aa_reg) << (2 * HW)) + (S2W'(ab_reg) << (HW + 1))
                         + S2W'(bb_reg);
            side5_reg <= side4_reg;
            l2_5_reg  <= l2_4_reg;
            r2_5_reg  <= r2_4_reg;
        end
    end

    // stage 6: radicand r2 - (l2 - s2); negative means the ray passes wide
    logic [NW-1:0] n_next;
    logic [NW-1:0] n_reg;
    side_t         side6_next;
    side_t         side6_reg;

    assign n_next = NW'(r2_5_reg) - NW'(l2_5_reg) + NW'(s2_reg);

    always_comb
    begin
        side6_next      = side5_reg;
        side6_next.miss = side5_reg.miss | n_next[NW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            n_reg     <= n_next;
            side6_reg <= side6_next;
        end
    end

    // square root, one root bit per stage
    logic [NW-1:0]  sq_rad_reg  [QW];
    logic [RMW-1:0] sq_rem_reg  [QW];
    logic [QW-1:0]  sq_root_reg [QW];
    side_t          sq_side_reg [QW];
    logic [NW-1:0]  sq_rad_in   [QW];
    logic [RMW-1:0] sq_rem_in   [QW];
    logic [QW-1:0]  sq_root_in  [QW];
    side_t          sq_side_in  [QW];
    logic [RMW-1:0] sq_trial    [QW];
    logic [RMW-1:0] sq_sub      [QW];

    always_comb
    begin
        sq_rad_in[0]  = n_reg;
        sq_rem_in[0]  = '0;
        sq_root_in[0] = '0;
        sq_side_in[0] = side6_reg;
        for (int j = 1; j < QW; j++)
        begin
            sq_rad_in[j]  = sq_rad_reg[j-1];
            sq_rem_in[j]  = sq_rem_reg[j-1];
            sq_root_in[j] = sq_root_reg[j-1];
            sq_side_in[j] = sq_side_reg[j-1];
        end
        for (int j = 0; j < QW; j++)
        begin
            sq_trial[j] = {sq_rem_in[j][RMW-3:0], sq_rad_in[j][NW-1:NW-2]};
            sq_sub[j]   = RMW'({sq_root_in[j], 2'b01});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QW; j++)
        begin
            if (en[SQ0+j])
            begin
                sq_rad_reg[j]  <= sq_rad_in[j] << 2;
                sq_side_reg[j] <= sq_side_in[j];
                if (sq_trial[j] >= sq_sub[j])
                begin
                    sq_rem_reg[j]  <= sq_trial[j] - sq_sub[j];
                    sq_root_reg[j] <= {sq_root_in[j][QW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[j]  <= sq_trial[j];
                    sq_root_reg[j] <= {sq_root_in[j][QW-2:0], 1'b0};
                end
            end
        end
    end

    // output stage: distance and saturation
    side_t                side_f;
    logic signed [EW-1:0] s_f;
    logic signed [EW-1:0] q_f;
    logic signed [EW-1:0] dist_sum;
    logic [DIST_W-1:0]    dist_sat;
    logic                 hit_reg;
    logic                 inside_reg;
    logic [DIST_W-1:0]    distance_reg;

    always_comb
    begin
        side_f   = sq_side_reg[QW-1];
        s_f      = side_f.sneg ? -$signed(EW'(side_f.sabs)) : $signed(EW'(side_f.sabs));
        q_f      = $signed(EW'(sq_root_reg[QW-1]));
        dist_sum = side_f.outside ? (s_f - q_f) : (s_f + q_f);
        if (dist_sum[EW-1])
        begin
            dist_sat = '0;
        end
        else if (|dist_sum[EW-2:DIST_W])
        begin
            dist_sat = '1;
        end
        else
        begin
            dist_sat = dist_sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            hit_reg      <= ~side_f.miss;
            inside_reg   <= ~side_f.miss & ~side_f.outside;
            distance_reg <= side_f.miss ? '0 : dist_sat;
        end
    end

    assign res.valid         = v_reg[NST-1];
    assign res.hit           = hit_reg;
    assign res.origin_inside = inside_reg;
    assign res.distance      = distance_reg;

    // a miss never reports a distance or an inside origin
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.distance == '0 && !res.origin_inside)
        else $error("miss beat carries distance or inside flag");

    // an empty output stage means every stage can advance
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NST-1] |-> ray.ready)
        else $error("input blocked with output stage empty");

    // a full first stage that cannot advance keeps its beat
    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !en[0] |=> v_reg[0])
        else $error("first stage dropped a held beat");

endmodule
